// ===== rtl/sbbc_pkg.sv =====
// ============================================================================
// sbbc_pkg
// Character codes shared by the script bracket balance checker.
// ============================================================================
`default_nettype none

package sbbc_pkg;

    // Escape and quote delimiters
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_BACKTICK  = 8'h60;

    // Regex and comment markers
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;

    // Bracket pairs
    localparam logic [7:0] CH_LCURLY    = 8'h7B;
    localparam logic [7:0] CH_RCURLY    = 8'h7D;
    localparam logic [7:0] CH_LROUND    = 8'h28;
    localparam logic [7:0] CH_RROUND    = 8'h29;
    localparam logic [7:0] CH_LSQUARE   = 8'h5B;
    localparam logic [7:0] CH_RSQUARE   = 8'h5D;

    // No byte before: reads as a plain byte, never a backslash
    localparam logic [7:0] CH_NONE      = 8'h00;

endpackage

`default_nettype wire

// ===== rtl/script_bracket_balance_check_top.sv =====
// ============================================================================
// script_bracket_balance_check_top
// Streams script text a byte per transaction and reports whether curly,
// round and square brackets balance outside strings and regex literals.
// ============================================================================
//
//  channel | dir | tdata                     | tuser       | tlast
//  --------+-----+---------------------------+-------------+-----------
//  s_      | in  | [7:0] text_byte           | empty_text  | final_byte
//  m_      | out | [0] balanced, [7:1] zero  | -           | -
//
//  One byte is taken every cycle while the result is not stalled; each byte is
//  held in the input register, then one pass of compare-and-count logic
//  updates the scan state. The verdict of a text goes from the input register
//  into the result register once its final byte is taken. Each byte is judged
//  when the next one arrives, since a slash needs its successor. Reset (aresetn
//  low, synchronous) clears all scan state. A stalled result holds the pipe;
//  the input side keeps taking bytes while the input register can move on.
// ============================================================================
`default_nettype none

module script_bracket_balance_check_top #(
    parameter int DEPTH_BITS = 16
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] text_byte
    input  wire logic       s_tlast,   // final_byte
    input  wire logic       s_tuser,   // [0] empty_text

    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [0] balanced, [7:1] zero
);

    // Running scan state
    typedef struct packed {
        logic [DEPTH_BITS-1:0] curly;
        logic [DEPTH_BITS-1:0] round;
        logic [DEPTH_BITS-1:0] square;
        logic                  in_quote;
        logic [7:0]            quote_char;
        logic                  regex_open;
        logic                  failed;
    } scan_t;

    localparam scan_t SCAN_RESET = '0;

    // Judge one byte against the scan state
    function automatic scan_t judge(input scan_t st, input logic [7:0] c,
                                    input logic [7:0] prev, input logic has_next,
                                    input logic [7:0] nxt);
        scan_t r;
        r = st;
        if (!st.failed) begin
            if (st.in_quote) begin
                if (c == st.quote_char && prev != sbbc_pkg::CH_BACKSLASH) begin
                    r.in_quote   = 1'b0;
                    r.quote_char = sbbc_pkg::CH_NONE;
                end
            end else if (st.regex_open) begin
                if (c == sbbc_pkg::CH_SLASH && prev != sbbc_pkg::CH_BACKSLASH) begin
                    r.regex_open = 1'b0;
                end
            end else begin
                case (c)
                    sbbc_pkg::CH_DQUOTE, sbbc_pkg::CH_SQUOTE, sbbc_pkg::CH_BACKTICK: begin
                        r.in_quote   = 1'b1;
                        r.quote_char = c;
                    end
                    sbbc_pkg::CH_SLASH: begin
                        if (prev != sbbc_pkg::CH_BACKSLASH && has_next &&
                            nxt != sbbc_pkg::CH_SLASH && nxt != sbbc_pkg::CH_STAR) begin
                            r.regex_open = 1'b1;
                        end
                    end
                    sbbc_pkg::CH_LCURLY: begin
                        if (&st.curly) r.failed = 1'b1;
                        else           r.curly  = st.curly + 1'b1;
                    end
                    sbbc_pkg::CH_RCURLY: begin
                        if (st.curly == '0) r.failed = 1'b1;
                        else                r.curly  = st.curly - 1'b1;
                    end
                    sbbc_pkg::CH_LROUND: begin
                        if (&st.round) r.failed = 1'b1;
                        else           r.round  = st.round + 1'b1;
                    end
                    sbbc_pkg::CH_RROUND: begin
                        if (st.round == '0) r.failed = 1'b1;
                        else                r.round  = st.round - 1'b1;
                    end
                    sbbc_pkg::CH_LSQUARE: begin
                        if (&st.square) r.failed = 1'b1;
                        else            r.square = st.square + 1'b1;
                    end
                    sbbc_pkg::CH_RSQUARE: begin
                        if (st.square == '0) r.failed = 1'b1;
                        else                 r.square = st.square - 1'b1;
                    end
                    default: begin
                        r = st;
                    end
                endcase
            end
        end
        return r;
    endfunction

    // Input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg,  in_byte_next;
    logic       in_last_reg,  in_last_next;
    logic       in_empty_reg, in_empty_next;

    // Scan state registers
    logic [7:0] held_byte_reg,   held_byte_next;
    logic       held_valid_reg,  held_valid_next;
    logic [7:0] byte_before_reg, byte_before_next;
    scan_t      scan_reg,        scan_next;

    // Result register
    logic       res_valid_reg, res_valid_next;
    logic       res_bal_reg,   res_bal_next;

    logic       advance;
    logic       step;
    logic       verdict;
    scan_t      scan_held;
    scan_t      scan_last;
    logic [7:0] prev_of_byte;

    // Move the pipe unless the result is stalled
    assign advance  = !res_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign verdict  = in_last_reg || in_empty_reg;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {7'd0, res_bal_reg};

    // Load the input register
    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        in_last_next  = in_last_reg;
        in_empty_next = in_empty_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_tdata;
            in_last_next  = s_tlast;
            in_empty_next = s_tuser;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    // Judge the held byte with the new byte as lookahead, then the final byte
    always_comb begin
        scan_held    = held_valid_reg ?
                       judge(scan_reg, held_byte_reg, byte_before_reg, 1'b1, in_byte_reg) :
                       scan_reg;
        prev_of_byte = held_valid_reg ? held_byte_reg : sbbc_pkg::CH_NONE;
        scan_last    = judge(scan_held, in_byte_reg, prev_of_byte, 1'b0, sbbc_pkg::CH_NONE);
    end

    // Update scan state and result
    always_comb begin
        held_byte_next   = held_byte_reg;
        held_valid_next  = held_valid_reg;
        byte_before_next = byte_before_reg;
        scan_next        = scan_reg;
        res_valid_next   = res_valid_reg;
        res_bal_next     = res_bal_reg;
        if (advance) begin
            res_valid_next = step && verdict;
        end
        if (step) begin
            if (verdict) begin
                held_byte_next   = 8'd0;
                held_valid_next  = 1'b0;
                byte_before_next = sbbc_pkg::CH_NONE;
                scan_next        = SCAN_RESET;
                res_bal_next     = in_empty_reg ||
                                   (!scan_last.failed && scan_last.curly == '0 &&
                                    scan_last.round == '0 && scan_last.square == '0 &&
                                    !scan_last.in_quote && !scan_last.regex_open);
            end else begin
                held_byte_next   = in_byte_reg;
                held_valid_next  = 1'b1;
                byte_before_next = prev_of_byte;
                scan_next        = scan_held;
            end
        end
    end

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            held_valid_reg  <= 1'b0;
            held_byte_reg   <= 8'd0;
            byte_before_reg <= sbbc_pkg::CH_NONE;
            scan_reg        <= SCAN_RESET;
            res_valid_reg   <= 1'b0;
        end else begin
            in_valid_reg    <= in_valid_next;
            held_valid_reg  <= held_valid_next;
            held_byte_reg   <= held_byte_next;
            byte_before_reg <= byte_before_next;
            scan_reg        <= scan_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        in_byte_reg  <= in_byte_next;
        in_last_reg  <= in_last_next;
        in_empty_reg <= in_empty_next;
        res_bal_reg  <= res_bal_next;
    end

`ifndef SYNTHESIS
    // A new result comes only from a final or empty item
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid_reg && !$past(res_valid_reg)) |->
            $past(in_valid_reg && (in_last_reg || in_empty_reg)))
        else $error("result without final item");

    // A verdict returns the scan to reset
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step && verdict) |=> (!held_valid_reg && scan_reg == SCAN_RESET))
        else $error("scan state not cleared after verdict");

    // A failure sticks until the verdict
    assert property (@(posedge aclk) disable iff (!aresetn)
        (scan_reg.failed && !(step && verdict)) |=> scan_reg.failed)
        else $error("failure flag dropped early");

    // A stalled result keeps its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid_reg && !m_tready) |=> (res_valid_reg && $stable(res_bal_reg)))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

// ===== bench/bracket_verdict_checker.sv =====
// ============================================================================
// bracket_verdict_checker
// Watches both stream channels of the bracket balance checker, rescans
// every accepted text byte with its own copy of the scan state, and compares
// each accepted verdict with the oldest one predicted.
// ============================================================================

module bracket_verdict_checker #(
    parameter int DEPTH_BITS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_byte
    input  logic       s_tlast,   // final_byte
    input  logic       s_tuser,   // [0] empty_text
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [0] balanced, [7:1] zero
    output int         fail_count,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_CAP = 100;

    // Scan state: held byte awaiting its lookahead, counters, open literals
    logic [7:0]            look_byte;
    logic                  look_valid;
    logic [7:0]            look_prev;
    logic [DEPTH_BITS-1:0] curly_cnt;
    logic [DEPTH_BITS-1:0] round_cnt;
    logic [DEPTH_BITS-1:0] square_cnt;
    logic                  quote_open;
    logic [7:0]            string_delim;
    logic                  regex_open;
    logic                  scan_failed;

    bit verdict_q[$];
    int mismatches = 0;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic note_mismatch(input string what);
        if (mismatches < PRINT_CAP)
            $display("%0t checker: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic void clear_scan();
        look_byte    = sbbc_pkg::CH_NONE;
        look_valid   = 1'b0;
        look_prev    = sbbc_pkg::CH_NONE;
        curly_cnt    = '0;
        round_cnt    = '0;
        square_cnt   = '0;
        quote_open   = 1'b0;
        string_delim = sbbc_pkg::CH_NONE;
        regex_open   = 1'b0;
        scan_failed  = 1'b0;
    endfunction

    // Open a level; a count already at its ceiling fails the text
    function automatic void level_up(inout logic [DEPTH_BITS-1:0] cnt);
        if (cnt == '1)
            scan_failed = 1'b1;
        else
            cnt = cnt + 1'b1;
    endfunction

    // Close a level; closing below zero fails the text
    function automatic void level_down(inout logic [DEPTH_BITS-1:0] cnt);
        if (cnt == '0)
            scan_failed = 1'b1;
        else
            cnt = cnt - 1'b1;
    endfunction

    // Judge one byte given the byte before it and, if any, the byte after it
    function automatic void scan_char(input logic [7:0] c, input logic [7:0] prev,
                                      input bit has_next, input logic [7:0] nxt);
        if (scan_failed) begin
            // verdict already settled
        end else if (quote_open) begin
            if (c == string_delim && prev != sbbc_pkg::CH_BACKSLASH) begin
                quote_open   = 1'b0;
                string_delim = sbbc_pkg::CH_NONE;
            end
        end else if (regex_open) begin
            if (c == sbbc_pkg::CH_SLASH && prev != sbbc_pkg::CH_BACKSLASH)
                regex_open = 1'b0;
        end else begin
            case (c)
                sbbc_pkg::CH_DQUOTE, sbbc_pkg::CH_SQUOTE, sbbc_pkg::CH_BACKTICK: begin
                    quote_open   = 1'b1;
                    string_delim = c;
                end
                sbbc_pkg::CH_SLASH: begin
                    if (prev != sbbc_pkg::CH_BACKSLASH && has_next &&
                        nxt != sbbc_pkg::CH_SLASH && nxt != sbbc_pkg::CH_STAR)
                        regex_open = 1'b1;
                end
                sbbc_pkg::CH_LCURLY:  level_up(curly_cnt);
                sbbc_pkg::CH_RCURLY:  level_down(curly_cnt);
                sbbc_pkg::CH_LROUND:  level_up(round_cnt);
                sbbc_pkg::CH_RROUND:  level_down(round_cnt);
                sbbc_pkg::CH_LSQUARE: level_up(square_cnt);
                sbbc_pkg::CH_RSQUARE: level_down(square_cnt);
                default: ;
            endcase
        end
    endfunction

    // Advance the scan by one accepted transaction; queue a verdict when due
    function automatic void predict_byte(input logic [7:0] b, input bit last, input bit empty);
        logic [7:0] prev_of_b;
        bit         ok;
        if (empty) begin
            clear_scan();
            verdict_q = {verdict_q, 1'b1};
        end else begin
            prev_of_b = sbbc_pkg::CH_NONE;
            if (look_valid) begin
                scan_char(look_byte, look_prev, 1'b1, b);
                prev_of_b = look_byte;
            end
            if (!last) begin
                look_prev  = prev_of_b;
                look_byte  = b;
                look_valid = 1'b1;
            end else begin
                scan_char(b, prev_of_b, 1'b0, sbbc_pkg::CH_NONE);
                ok = !scan_failed && curly_cnt == '0 && round_cnt == '0 &&
                     square_cnt == '0 && !quote_open && !regex_open;
                clear_scan();
                verdict_q = {verdict_q, ok};
            end
        end
    endfunction

    initial clear_scan();

    // Sample both channels at each rising edge
    always @(posedge aclk) begin
        bit want;
        if (!aresetn) begin
            clear_scan();
            verdict_q.delete();
        end else begin
            if (s_tvalid && s_tready)
                predict_byte(s_tdata, s_tlast, s_tuser);
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    note_mismatch($sformatf("verdict %b with no text pending", m_tdata[0]));
                end else begin
                    want = verdict_q.pop_front();
                    if (m_tdata[0] !== want)
                        note_mismatch($sformatf("balanced got %b want %b", m_tdata[0], want));
                    if (m_tdata[7:1] !== 7'd0)
                        note_mismatch($sformatf("pad bits got %h want 0", m_tdata[7:1]));
                end
            end
        end
        fail_count <= mismatches;
        pending    <= verdict_q.size();
    end

endmodule

// ===== bench/tb_script_bracket_balance_check_top.sv =====
// ============================================================================
// tb_script_bracket_balance_check_top
// Feeds script text to the bracket balance checker: a short directed set,
// random texts built mostly from nested brackets, strings and regex literals,
// and two runs that drive the depth counters to their ceiling. A separate
// checker predicts and compares every verdict; this module gives the result.
// ============================================================================

module tb_script_bracket_balance_check_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Narrow counters keep the ceiling runs short
    localparam int          DEPTH_BITS    = 4;
    localparam int unsigned DEPTH_MAX     = (1 << DEPTH_BITS) - 1;
    localparam int          PHASE_ITEMS   = 370;
    localparam int          RX_HOLD_CYCLES = 300;
    localparam int          DRAIN_CYCLES  = 20;

    logic       aclk;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       s_tuser  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    int         fail_count;
    int         pending;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit rx_hold_req = 1'b0;
    int items_sent  = 0;

    logic [7:0] script_q[$];

    script_bracket_balance_check_top #(.DEPTH_BITS(DEPTH_BITS)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    bracket_verdict_checker #(.DEPTH_BITS(DEPTH_BITS)) verdict_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hard stop for a hung run
    initial begin
        #4_000_000;
        $display("[script_bracket_balance_check_top] ERROR");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                rx_hold_req = 1'b0;
            end
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Offer one transaction after random idle cycles; hold until accepted
    task automatic put_byte(input logic [7:0] b, input bit last, input bit empty);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        s_tuser  <= empty;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i], i == s.len() - 1, 1'b0);
    endtask

    task automatic send_run(input logic [7:0] b, input int unsigned count, input bit close);
        for (int unsigned i = 0; i < count; i++)
            put_byte(b, close && i == count - 1, 1'b0);
    endtask

    // Drop the offer and hold the sender until every verdict in flight is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Append one byte to the text being built
    function automatic void add_byte(input logic [7:0] b);
        script_q = {script_q, b};
    endfunction

    function automatic logic [7:0] pick_quote();
        case ($urandom_range(0, 2))
            0:       return sbbc_pkg::CH_DQUOTE;
            1:       return sbbc_pkg::CH_SQUOTE;
            default: return sbbc_pkg::CH_BACKTICK;
        endcase
    endfunction

    // Half the time a character the scanner cares about or a zero byte, else any byte
    function automatic logic [7:0] pick_noise();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 12))
            0:       return sbbc_pkg::CH_BACKSLASH;
            1:       return sbbc_pkg::CH_DQUOTE;
            2:       return sbbc_pkg::CH_SQUOTE;
            3:       return sbbc_pkg::CH_BACKTICK;
            4:       return sbbc_pkg::CH_SLASH;
            5:       return sbbc_pkg::CH_STAR;
            6:       return sbbc_pkg::CH_LCURLY;
            7:       return sbbc_pkg::CH_RCURLY;
            8:       return sbbc_pkg::CH_LROUND;
            9:       return sbbc_pkg::CH_RROUND;
            10:      return sbbc_pkg::CH_LSQUARE;
            11:      return sbbc_pkg::CH_RSQUARE;
            default: return sbbc_pkg::CH_NONE;
        endcase
    endfunction

    // Build one text: mostly well-formed nesting with random content
    function automatic void build_script(input int max_len);
        logic [7:0] closers_q[$];
        logic [7:0] delim;
        logic [7:0] c;
        int         n;
        script_q.delete();
        n = $urandom_range(1, max_len);
        if ($urandom_range(0, 99) < 20) begin
            for (int i = 0; i < n; i++)
                add_byte(pick_noise());
        end else begin
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        case ($urandom_range(0, 2))
                            0: begin
                                add_byte(sbbc_pkg::CH_LCURLY);
                                closers_q = {closers_q, sbbc_pkg::CH_RCURLY};
                            end
                            1: begin
                                add_byte(sbbc_pkg::CH_LROUND);
                                closers_q = {closers_q, sbbc_pkg::CH_RROUND};
                            end
                            default: begin
                                add_byte(sbbc_pkg::CH_LSQUARE);
                                closers_q = {closers_q, sbbc_pkg::CH_RSQUARE};
                            end
                        endcase
                    end
                    2: begin
                        if (closers_q.size() != 0)
                            add_byte(closers_q.pop_back());
                    end
                    3: begin
                        // quoted string, sometimes with an escaped delimiter
                        delim = pick_quote();
                        add_byte(delim);
                        repeat ($urandom_range(0, 4)) begin
                            if ($urandom_range(0, 3) == 0) begin
                                add_byte(sbbc_pkg::CH_BACKSLASH);
                                add_byte(delim);
                            end else begin
                                c = pick_noise();
                                add_byte((c == delim) ? 8'h78 : c);
                            end
                        end
                        add_byte(delim);
                    end
                    4: begin
                        // regex literal; first body byte must not be a slash or star
                        add_byte(sbbc_pkg::CH_SLASH);
                        add_byte(8'(8'h61 + $urandom_range(0, 25)));
                        repeat ($urandom_range(0, 3)) begin
                            c = pick_noise();
                            add_byte((c == sbbc_pkg::CH_SLASH) ? sbbc_pkg::CH_BACKSLASH : c);
                        end
                        add_byte(sbbc_pkg::CH_SLASH);
                    end
                    5: begin
                        add_byte(sbbc_pkg::CH_SLASH);
                        add_byte($urandom_range(0, 1) ? sbbc_pkg::CH_SLASH : sbbc_pkg::CH_STAR);
                    end
                    6: add_byte(pick_noise());
                    default: add_byte(8'(8'h61 + $urandom_range(0, 25)));
                endcase
            end
            if ($urandom_range(0, 99) < 90)
                while (closers_q.size() != 0)
                    add_byte(closers_q.pop_back());
        end
    endfunction

    // Send the built text; now and then abandon it with an empty-text flag
    task automatic send_script();
        int cut;
        cut = ($urandom_range(0, 99) < 4) ? int'($urandom_range(0, script_q.size() - 1)) : -1;
        foreach (script_q[i]) begin
            if (i == cut) begin
                put_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
                return;
            end
            put_byte(script_q[i], i == script_q.size() - 1, 1'b0);
        end
    endtask

    task automatic send_random(input int max_len);
        if ($urandom_range(0, 99) < 4) begin
            put_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end else begin
            build_script(max_len);
            send_script();
        end
    endtask

    task automatic run_phase(input int goal);
        while (items_sent < goal)
            send_random(24);
    endtask

    // Stimulus and verdict
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed texts
        tx_idle_pct = 13;
        rx_idle_pct = 66;
        put_byte(8'hFF, 1'b1, 1'b1);     // empty text
        send_text("{}");
        send_text(")");                  // close at zero depth
        send_text("][]");                // failure sticks after rebalancing
        send_text("\"\\\"\"");           // escaped quote inside a string
        send_text("/(/");                // bracket hidden in a regex
        send_text("\\'");                // quote after backslash still opens
        send_text("/");                  // slash with no lookahead
        send_text("\\/x");               // escaped slash opens nothing
        put_byte(sbbc_pkg::CH_LCURLY, 1'b0, 1'b0); // partial text abandoned
        put_byte(8'h00, 1'b0, 1'b1);
        put_byte(8'h00, 1'b0, 1'b0);     // byte extremes
        put_byte(8'hFF, 1'b1, 1'b0);

        // Random texts, one idling pattern per phase
        run_phase(items_sent + PHASE_ITEMS);
        wait_drained();

        tx_idle_pct = 66;
        rx_idle_pct = 13;
        run_phase(items_sent + PHASE_ITEMS);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_req = 1'b1;
        repeat (60) send_random(3);
        wait_drained();
        run_phase(items_sent + PHASE_ITEMS);

        // Depth ceiling: a full count that closes cleanly, then one past it
        send_run(sbbc_pkg::CH_LCURLY, DEPTH_MAX, 1'b0);
        send_run(sbbc_pkg::CH_RCURLY, DEPTH_MAX, 1'b1);
        send_run(sbbc_pkg::CH_LROUND, DEPTH_MAX + 1, 1'b0);
        send_run(sbbc_pkg::CH_RROUND, DEPTH_MAX, 1'b1);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("[script_bracket_balance_check_top] OK");
        else
            $display("[script_bracket_balance_check_top] ERROR");
        $finish;
    end

endmodule
